### rtl/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types, constants and helpers of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mva_pkg;

  localparam int MaxVertices = 4096;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CoordW      = 16;
  localparam int SumW        = 21;
  localparam int VecW        = 36;
  localparam int NormW       = 16;

  localparam logic signed [SumW-1:0] SumMax = 21'sd1048575;
  localparam logic signed [SumW-1:0] SumMin = -21'sd1048576;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // status and result of the normaliser
  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nz;
  } norm_res_t;

  // saturating add of a unit component to a sum component
  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] s,
                                                      input logic signed [NormW-1:0] n);
    logic signed [SumW:0] t;
    t = $signed({s[SumW-1], s}) + $signed({{(SumW+1-NormW){n[NormW-1]}}, n});
    if (t > $signed({SumMax[SumW-1], SumMax})) begin
      return SumMax;
    end else if (t < $signed({SumMin[SumW-1], SumMin})) begin
      return SumMin;
    end else begin
      return t[SumW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/mva_norm.sv
// ----------------------------------------------------------------------------
// mva_norm
// Iterative normaliser: scales a vector to Q1.14 unit length with a shift
// search, one shared squarer, a bit-pair square root and a restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mva_norm (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic signed [mva_pkg::VecW-1:0] vx,
  input  wire logic signed [mva_pkg::VecW-1:0] vy,
  input  wire logic signed [mva_pkg::VecW-1:0] vz,
  output mva_pkg::norm_res_t                   res
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DLOAD = 6'b010000,
    N_DIV   = 6'b100000
  } nstate_t;

  nstate_t                                state;
  logic [2:0][mva_pkg::VecW-1:0]          mag;
  logic [2:0]                             neg;
  logic [4:0]                             cnt;
  logic [1:0]                             comp;
  logic [61:0]                            prod;
  logic [63:0]                            ssum;
  logic [63:0]                            rs;
  logic [63:0]                            root;
  logic [63:0]                            bitv;
  logic [31:0]                            rem;
  logic [14:0]                            lo;
  logic [14:0]                            quo;
  logic [2:0][mva_pkg::NormW-1:0]         nvec;
  logic                                   done;
  logic                                   zero;

  logic [mva_pkg::VecW-1:0]               mmax;
  logic [1:0]                             sqsel;
  logic [30:0]                            sqin;
  logic [31:0]                            len;
  logic [45:0]                            num;
  logic [32:0]                            trial;
  logic                                   ge;
  logic [14:0]                            quo_next;
  logic [63:0]                            rb;

  function automatic logic [mva_pkg::VecW-1:0] absv(input logic signed [mva_pkg::VecW-1:0] v);
    return v[mva_pkg::VecW-1] ? mva_pkg::VecW'(-v) : mva_pkg::VecW'(v);
  endfunction

  // largest magnitude, operand of the squarer, divider step
  always_comb begin
    mmax = mag[0];
    if (mag[1] > mmax) begin
      mmax = mag[1];
    end
    if (mag[2] > mmax) begin
      mmax = mag[2];
    end
    sqsel    = (cnt[1:0] == 2'd3) ? 2'd0 : cnt[1:0];
    sqin     = mag[sqsel][30:0];
    len      = root[31:0];
    num      = {1'b0, mag[comp][30:0], 14'b0} + 46'(len >> 1);
    trial    = {rem, lo[14]};
    ge       = trial >= {1'b0, len};
    quo_next = {quo[13:0], ge};
    rb       = root + bitv;
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            neg    <= {vz[mva_pkg::VecW-1], vy[mva_pkg::VecW-1], vx[mva_pkg::VecW-1]};
            mag[0] <= absv(vx);
            mag[1] <= absv(vy);
            mag[2] <= absv(vz);
            state  <= N_SHIFT;
          end
        end
        // bring the largest magnitude into [2^30, 2^31), one bit a cycle; a zero vector finishes with zero set
        N_SHIFT: begin
          if (mmax == '0) begin
            zero  <= 1'b1;
            nvec  <= '0;
            done  <= 1'b1;
            state <= N_IDLE;
          end else if (|mmax[mva_pkg::VecW-1:31]) begin
            mag[0] <= mag[0] >> 1;
            mag[1] <= mag[1] >> 1;
            mag[2] <= mag[2] >> 1;
          end else if (!mmax[30]) begin
            mag[0] <= mag[0] << 1;
            mag[1] <= mag[1] << 1;
            mag[2] <= mag[2] << 1;
          end else begin
            cnt   <= '0;
            ssum  <= '0;
            state <= N_SQ;
          end
        end
        // sum of squares through one registered multiplier
        N_SQ: begin
          if (cnt[1:0] != 2'd3) begin
            prod <= sqin * sqin;
          end
          if (cnt[1:0] == 2'd3) begin
            rs    <= ssum + {2'b0, prod};
            root  <= '0;
            bitv  <= 64'd1 << 62;
            cnt   <= '0;
            state <= N_SQRT;
          end else begin
            if (cnt[1:0] != 2'd0) begin
              ssum <= ssum + {2'b0, prod};
            end
            cnt <= cnt + 5'd1;
          end
        end
        // integer square root, one bit pair a cycle
        N_SQRT: begin
          if (rs >= rb) begin
            rs   <= rs - rb;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            comp  <= '0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          rem   <= {1'b0, num[45:15]};
          lo    <= num[14:0];
          quo   <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        // restoring division, one quotient bit a cycle
        N_DIV: begin
          rem <= ge ? 32'(trial - {1'b0, len}) : trial[31:0];
          quo <= quo_next;
          lo  <= lo << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd14) begin
            nvec[comp] <= neg[comp] ? mva_pkg::NormW'(-{1'b0, quo_next})
                                    : mva_pkg::NormW'({1'b0, quo_next});
            if (comp == 2'd2) begin
              zero  <= 1'b0;
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_DLOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.zero = zero;
  assign res.nx   = $signed(nvec[0]);
  assign res.ny   = $signed(nvec[1]);
  assign res.nz   = $signed(nvec[2]);

endmodule

`default_nettype wire

### rtl/mesh_vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator
// Smooth per-vertex normals of a triangle mesh by summing unit face normals.
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken at
// that edge. After the accepting edge busy stays high for 1 cycle for a
// load; for a read or a triangle it stays high while the shared normaliser
// (shift search one bit a cycle, a squarer, a bit-pair square root and three
// divisions) and the single-port position and sum memories do their work;
// unknown codes leave busy low. A read gives its result on the result
// ports, marked by done for one cycle; the receiver cannot hold it off, so
// it must take every transfer as it comes. Loads, triangles and unknown
// codes give no result. Memories are not cleared: a vertex must be loaded
// before it is used.
`timescale 1ns / 1ps
`default_nettype none

module mesh_vertex_normal_accumulator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [1:0]                        operation,
  input  wire logic [mva_pkg::IdxW-1:0]          vertex_index,
  input  wire logic signed [mva_pkg::CoordW-1:0] pos_x,
  input  wire logic signed [mva_pkg::CoordW-1:0] pos_y,
  input  wire logic signed [mva_pkg::CoordW-1:0] pos_z,
  input  wire logic [mva_pkg::IdxW-1:0]          corner_second,
  input  wire logic [mva_pkg::IdxW-1:0]          corner_third,
  output      logic                              done,
  output      logic signed [mva_pkg::NormW-1:0]  normal_x,
  output      logic signed [mva_pkg::NormW-1:0]  normal_y,
  output      logic signed [mva_pkg::NormW-1:0]  normal_z,
  output      logic                              sum_too_short
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOAD   = 9'b000000010,
    S_PRD    = 9'b000000100,
    S_PLAST  = 9'b000001000,
    S_CROSS  = 9'b000010000,
    S_NSTART = 9'b000100000,
    S_NWAIT  = 9'b001000000,
    S_SRD    = 9'b010000000,
    S_SWR    = 9'b100000000
  } state_t;

  localparam int PosW = 3 * mva_pkg::CoordW;
  localparam int SmW  = 3 * mva_pkg::SumW;

  state_t                           state;
  mva_pkg::op_t                     op;
  logic [2:0][mva_pkg::IdxW-1:0]    idx;
  logic [PosW-1:0]                  pin;
  logic [1:0]                       cnt;
  logic [2:0]                       mcnt;
  logic [2:0][mva_pkg::CoordW-1:0]  v0;
  logic [2:0][16:0]                 e1;
  logic [2:0][16:0]                 e2;
  logic signed [33:0]               prod;
  logic [2:0][34:0]                 cv;

  logic [PosW-1:0]                  pos_mem [mva_pkg::MaxVertices];
  logic [SmW-1:0]                   sum_mem [mva_pkg::MaxVertices];
  logic [PosW-1:0]                  pos_rdata;
  logic [SmW-1:0]                   sum_rdata;
  logic [mva_pkg::IdxW-1:0]         addr;
  logic                             sum_we;
  logic [SmW-1:0]                   sum_wdata;

  logic                             norm_start;
  logic signed [mva_pkg::VecW-1:0]  nvx, nvy, nvz;
  mva_pkg::norm_res_t               nres;

  logic [1:0]                       cap_sel;
  logic [2:0][mva_pkg::CoordW-1:0]  pdat;
  logic signed [16:0]               ma, mb;

  // shared address, memory write data, multiplier operands
  always_comb begin
    addr      = idx[cnt];
    cap_sel   = (state == S_PLAST) ? 2'd2 : 2'(cnt - 2'd1);
    pdat      = pos_rdata;
    sum_we    = (state == S_LOAD) || (state == S_SWR);
    sum_wdata = '0;
    if (state == S_SWR) begin
      sum_wdata = {mva_pkg::sat_add($signed(sum_rdata[62:42]), nres.nz),
                   mva_pkg::sat_add($signed(sum_rdata[41:21]), nres.ny),
                   mva_pkg::sat_add($signed(sum_rdata[20:0]),  nres.nx)};
    end
    case (mcnt)
      3'd0:    begin ma = $signed(e1[1]); mb = $signed(e2[2]); end
      3'd1:    begin ma = $signed(e1[2]); mb = $signed(e2[1]); end
      3'd2:    begin ma = $signed(e1[2]); mb = $signed(e2[0]); end
      3'd3:    begin ma = $signed(e1[0]); mb = $signed(e2[2]); end
      3'd4:    begin ma = $signed(e1[0]); mb = $signed(e2[1]); end
      3'd5:    begin ma = $signed(e1[1]); mb = $signed(e2[0]); end
      default: begin ma = '0;             mb = '0;             end
    endcase
    norm_start = (state == S_NSTART);
    if (op == mva_pkg::OP_READ) begin
      nvx = mva_pkg::VecW'($signed(sum_rdata[20:0]));
      nvy = mva_pkg::VecW'($signed(sum_rdata[41:21]));
      nvz = mva_pkg::VecW'($signed(sum_rdata[62:42]));
    end else begin
      nvx = mva_pkg::VecW'($signed(cv[0]));
      nvy = mva_pkg::VecW'($signed(cv[1]));
      nvz = mva_pkg::VecW'($signed(cv[2]));
    end
  end

  // position and sum memories, registered reads
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      pos_mem[addr] <= pin;
    end
    if (sum_we) begin
      sum_mem[addr] <= sum_wdata;
    end
    pos_rdata <= pos_mem[addr];
    sum_rdata <= sum_mem[addr];
  end

  mva_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vx    (nvx),
    .vy    (nvy),
    .vz    (nvz),
    .res   (nres)
  );

  // item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op  <= mva_pkg::op_t'(operation);
            idx <= {corner_third, corner_second, vertex_index};
            pin <= {pos_z, pos_y, pos_x};
            cnt <= '0;
            case (mva_pkg::op_t'(operation))
              mva_pkg::OP_LOAD: state <= S_LOAD;
              mva_pkg::OP_TRI:  state <= S_PRD;
              mva_pkg::OP_READ: state <= S_SRD;
              default:          state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state <= S_IDLE;
        // fetch the three corners; edges formed as they arrive
        S_PRD, S_PLAST: begin
          if (state == S_PLAST || cnt != 2'd0) begin
            for (int k = 0; k < 3; k++) begin
              case (cap_sel)
                2'd0:    v0[k] <= pdat[k];
                2'd1:    e1[k] <= 17'($signed(pdat[k])) - 17'($signed(v0[k]));
                default: e2[k] <= 17'($signed(pdat[k])) - 17'($signed(v0[k]));
              endcase
            end
          end
          if (state == S_PLAST) begin
            mcnt  <= '0;
            state <= S_CROSS;
          end else if (cnt == 2'd2) begin
            state <= S_PLAST;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        // cross product: six products through one multiplier
        S_CROSS: begin
          prod <= ma * mb;
          case (mcnt)
            3'd1:    cv[0] <= 35'(prod);
            3'd2:    cv[0] <= cv[0] - 35'(prod);
            3'd3:    cv[1] <= 35'(prod);
            3'd4:    cv[1] <= cv[1] - 35'(prod);
            3'd5:    cv[2] <= 35'(prod);
            3'd6:    cv[2] <= cv[2] - 35'(prod);
            default: ;
          endcase
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd6) begin
            state <= S_NSTART;
          end
        end
        S_NSTART: state <= S_NWAIT;
        S_NWAIT: begin
          if (nres.done) begin
            cnt <= '0;
            if (op == mva_pkg::OP_READ) begin
              normal_x      <= nres.nx;
              normal_y      <= nres.ny;
              normal_z      <= nres.nz;
              sum_too_short <= nres.zero;
              done          <= 1'b1;
              state         <= S_IDLE;
            end else if (nres.zero) begin
              state <= S_IDLE;
            end else begin
              state <= S_SRD;
            end
          end
        end
        S_SRD: state <= (op == mva_pkg::OP_READ) ? S_NSTART : S_SWR;
        // accumulate the face normal into each corner in turn
        S_SWR: begin
          if (cnt == 2'd2) begin
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 2'd1;
            state <= S_SRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_NWAIT) && $past(nres.done))
    else $error("result strobe without normaliser completion");
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (done && sum_too_short) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("short sum with nonzero normal");
  a_swr_after_srd: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWR) |-> $past(state == S_SRD))
    else $error("sum write without preceding read");

endmodule

`default_nettype wire
